>>> sv/sfd_pkg.sv
// Shared types, constants and helpers for the sample frame deframer.
// No dependencies; imported by sample_frame_deframer_core.
package sfd_pkg;

  // Default sizing
  localparam int SFD_SAMPLES_PER_CHANNEL = 64;
  localparam int SFD_MAX_CHANNELS        = 8;
  localparam int SFD_ACK_BYTES           = 4;

  // Operation codes carried in the input tuser
  localparam logic [1:0] OP_ARM  = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_CHANNEL_MASK  = 2'd0;
  localparam logic [1:0] REG_CONTROL_VALUE = 2'd1;
  localparam logic [1:0] REG_EXPECTED_ACK  = 2'd2;

  // Stream widths
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 2;

  // Result queue
  localparam int RES_DEPTH = 4;
  localparam int RES_PW    = 2;
  localparam int RES_CW    = 3;

  // Flags that travel from the parse stage to the multiply stage
  typedef struct packed {
    logic ack_complete;
    logic ack_match;
    logic frame_done;
    logic framing_error;
    logic rd_valid;
  } stage_flags_t;

  // One result item
  typedef struct packed {
    logic        sample_valid;
    logic [15:0] sample_value;
    logic        framing_error;
    logic        frame_done;
    logic        ack_match;
    logic        ack_complete;
  } result_t;

  // Channel positions per frame: popcount of the mask, at least one, capped
  function automatic logic [3:0] chan_count(input logic [7:0] mask,
                                            input logic [3:0] max_ch);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, mask[i]};
    end
    if (n == 4'd0) begin
      n = 4'd1;
    end
    if (n > max_ch) begin
      n = max_ch;
    end
    return n;
  endfunction

endpackage

>>> sv/sample_frame_deframer_core.sv
// An accepted item passes through the stage 1 register and then the result queue.
// Throughput: one item per cycle; the 4-entry result queue with a registered
// input ready sustains that rate while the output side takes a result per cycle.
// Gain and sample stores are synchronous-read memories, double banked; a frame
// commit flips the bank select and marks a frame available. Reset (rst, synchronous) clears parser,
// registers, bank select and result queue; the stores are not cleared.
// Depends on sfd_pkg.
module sample_frame_deframer_core
  import sfd_pkg::*;
#(
  parameter int SAMPLES_PER_CHANNEL = SFD_SAMPLES_PER_CHANNEL,
  parameter int MAX_CHANNELS        = SFD_MAX_CHANNELS,
  parameter int ACK_BYTES           = SFD_ACK_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [7:0] byte_value, [10:8] read_channel, [16:11] read_index, [23:17] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // [1:0] op
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  // output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [0] ack_complete, [1] ack_match, [2] frame_done, [3] framing_error,
  // [19:4] sample_value, [20] sample_valid, [23:21] zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SP_W    = (SAMPLES_PER_CHANNEL > 1) ? $clog2(SAMPLES_PER_CHANNEL) : 1;
  localparam int ACK_W   = 8 * ACK_BYTES;
  localparam int ACK_CW  = $clog2(ACK_BYTES + 1);
  localparam int GAIN_AW = 1 + CH_W;
  localparam int RAW_AW  = 1 + CH_W + SP_W;
  localparam int RI_W    = (SP_W > 6) ? SP_W : 6;
  localparam int CMP_W   = RI_W + 1;

  localparam logic [3:0]        MAX_CH  = 4'(MAX_CHANNELS);
  localparam logic [SP_W:0]     SPC_S   = (SP_W + 1)'(SAMPLES_PER_CHANNEL);
  localparam logic [CMP_W-1:0]  SPC_R   = CMP_W'(SAMPLES_PER_CHANNEL);
  localparam logic [ACK_CW-1:0] ACK_END = ACK_CW'(ACK_BYTES);

  typedef enum logic [2:0] {
    PS_FIRST,
    PS_GAIN,
    PS_DATA,
    PS_CONTROL,
    PS_FAILURE
  } parse_state_t;

  // Input field split
  logic [1:0] op;
  logic [7:0] byte_value;
  logic [2:0] read_channel;
  logic [5:0] read_index;

  assign op           = s_tuser[1:0];
  assign byte_value   = s_tdata[7:0];
  assign read_channel = s_tdata[10:8];
  assign read_index   = s_tdata[16:11];

  // Configuration registers
  logic [7:0]  channel_mask;
  logic [7:0]  control_value;
  logic [31:0] expected_ack;

  // Parser state
  parse_state_t      parse_state, parse_state_next;
  logic [ACK_CW-1:0] ack_count, ack_count_next;
  logic [ACK_W-1:0]  ack_bytes, ack_bytes_next;
  logic [CH_W-1:0]   channel_pos, channel_pos_next;
  logic [SP_W-1:0]   sample_pos, sample_pos_next;
  logic              committed_bank, committed_bank_next;
  logic              frame_available, frame_available_next;

  // Stores
  logic [7:0] gain_mem [2**GAIN_AW];
  logic [7:0] raw_mem  [2**RAW_AW];
  logic [7:0] gain_rd;
  logic [7:0] raw_rd;

  // Stage and queue
  logic            s1_valid;
  stage_flags_t    s1_flags;
  stage_flags_t    flags_next;
  result_t         res_mem [RES_DEPTH];
  result_t         res_head;
  result_t         res_new;
  logic [RES_PW-1:0] wr_ptr;
  logic [RES_PW-1:0] rd_ptr;
  logic [RES_CW-1:0] res_count;
  logic [RES_CW-1:0] res_count_next;

  logic             accept;
  logic             pop;
  logic [3:0]       nch;
  logic             is_ctl;
  logic             gain_we;
  logic             raw_we;
  logic             rd_en;
  logic [GAIN_AW-1:0] gain_waddr, gain_raddr;
  logic [RAW_AW-1:0]  raw_waddr, raw_raddr;
  logic [RI_W-1:0]    ri_ext;
  logic [63:0]        exp_ext;
  logic [ACK_W-1:0]   ack_want;
  logic [SP_W:0]      sp_inc;
  logic [3:0]         ch_inc;

  assign accept = s_tvalid && s_tready;
  assign pop    = m_tvalid && m_tready;
  assign nch    = chan_count(channel_mask, MAX_CH);
  assign is_ctl = (byte_value == control_value);

  assign exp_ext  = {32'd0, expected_ack};
  assign ack_want = exp_ext[ACK_W-1:0];
  assign sp_inc   = {1'b0, sample_pos} + (SP_W + 1)'(1);
  assign ch_inc   = 4'(channel_pos) + 4'd1;
  assign ri_ext   = RI_W'(read_index);

  assign gain_waddr = {~committed_bank, channel_pos};
  assign raw_waddr  = {~committed_bank, channel_pos, sample_pos};
  assign gain_raddr = {committed_bank, read_channel[CH_W-1:0]};
  assign raw_raddr  = {committed_bank, read_channel[CH_W-1:0], ri_ext[SP_W-1:0]};

  // Parse one item: arm, byte, read or nop
  always_comb begin
    parse_state_next     = parse_state;
    ack_count_next       = ack_count;
    ack_bytes_next       = ack_bytes;
    channel_pos_next     = channel_pos;
    sample_pos_next      = sample_pos;
    committed_bank_next  = committed_bank;
    frame_available_next = frame_available;
    flags_next           = '0;
    gain_we              = 1'b0;
    raw_we               = 1'b0;
    rd_en                = 1'b0;

    unique case (op)
      OP_ARM: begin
        ack_count_next   = '0;
        ack_bytes_next   = '0;
        channel_pos_next = '0;
        sample_pos_next  = '0;
        parse_state_next = PS_GAIN;
      end
      OP_BYTE: begin
        if (ack_count < ACK_END) begin
          // capture one acknowledge byte
          for (int i = 0; i < ACK_BYTES; i++) begin
            if (ack_count == ACK_CW'(i)) begin
              ack_bytes_next[8*i +: 8] = byte_value;
            end
          end
          ack_count_next = ack_count + ACK_CW'(1);
          if (ack_count_next == ACK_END) begin
            flags_next.ack_complete = 1'b1;
            flags_next.ack_match    = (ack_bytes_next == ack_want);
          end
        end else begin
          unique case (parse_state)
            PS_FIRST: begin
              if (is_ctl) begin
                parse_state_next = PS_GAIN;
              end
            end
            PS_FAILURE: begin
              if (is_ctl) begin
                channel_pos_next = '0;
                sample_pos_next  = '0;
                parse_state_next = PS_GAIN;
              end
            end
            PS_CONTROL: begin
              if (is_ctl) begin
                // commit: swap banks
                committed_bank_next   = ~committed_bank;
                frame_available_next  = 1'b1;
                flags_next.frame_done = 1'b1;
                channel_pos_next      = '0;
                sample_pos_next       = '0;
                parse_state_next      = PS_GAIN;
              end else begin
                parse_state_next         = PS_FAILURE;
                flags_next.framing_error = 1'b1;
              end
            end
            PS_GAIN: begin
              if (is_ctl) begin
                parse_state_next         = PS_FAILURE;
                flags_next.framing_error = 1'b1;
              end else begin
                gain_we          = 1'b1;
                parse_state_next = PS_DATA;
              end
            end
            PS_DATA: begin
              if (is_ctl) begin
                parse_state_next         = PS_FAILURE;
                flags_next.framing_error = 1'b1;
              end else begin
                raw_we = 1'b1;
                if (sp_inc >= SPC_S) begin
                  sample_pos_next = '0;
                  if (ch_inc >= nch) begin
                    channel_pos_next = '0;
                    parse_state_next = PS_CONTROL;
                  end else begin
                    channel_pos_next = channel_pos + CH_W'(1);
                    parse_state_next = PS_GAIN;
                  end
                end else begin
                  sample_pos_next = sp_inc[SP_W-1:0];
                end
              end
            end
            default: begin
              parse_state_next = PS_FIRST;
            end
          endcase
        end
      end
      OP_READ: begin
        rd_en = 1'b1;
        flags_next.rd_valid = frame_available && ({1'b0, read_channel} < nch) &&
                              (CMP_W'(read_index) < SPC_R);
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_mask  <= 8'd1;
      control_value <= 8'd255;
      expected_ack  <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CHANNEL_MASK:  channel_mask  <= cfg_wdata[7:0];
        REG_CONTROL_VALUE: control_value <= cfg_wdata[7:0];
        REG_EXPECTED_ACK:  expected_ack  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state     <= PS_FIRST;
      ack_count       <= ACK_END;
      ack_bytes       <= '0;
      channel_pos     <= '0;
      sample_pos      <= '0;
      committed_bank  <= 1'b0;
      frame_available <= 1'b0;
    end else if (accept) begin
      parse_state     <= parse_state_next;
      ack_count       <= ack_count_next;
      ack_bytes       <= ack_bytes_next;
      channel_pos     <= channel_pos_next;
      sample_pos      <= sample_pos_next;
      committed_bank  <= committed_bank_next;
      frame_available <= frame_available_next;
    end
  end

  // Gain store: write uncommitted bank, read committed bank
  always_ff @(posedge clk) begin
    if (accept && gain_we) begin
      gain_mem[gain_waddr] <= byte_value;
    end
    if (accept && rd_en) begin
      gain_rd <= gain_mem[gain_raddr];
    end
  end

  // Sample store: write uncommitted bank, read committed bank
  always_ff @(posedge clk) begin
    if (accept && raw_we) begin
      raw_mem[raw_waddr] <= byte_value;
    end
    if (accept && rd_en) begin
      raw_rd <= raw_mem[raw_raddr];
    end
  end

  // Stage 1 flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_flags <= flags_next;
  end

  // Form the result: multiply gain by sample
  always_comb begin
    res_new               = '0;
    res_new.ack_complete  = s1_flags.ack_complete;
    res_new.ack_match     = s1_flags.ack_match;
    res_new.frame_done    = s1_flags.frame_done;
    res_new.framing_error = s1_flags.framing_error;
    res_new.sample_valid  = s1_flags.rd_valid;
    if (s1_flags.rd_valid) begin
      res_new.sample_value = 16'(gain_rd) * 16'(raw_rd);
    end
  end

  // Result queue
  assign res_count_next = res_count + RES_CW'(s1_valid) - RES_CW'(pop);

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      res_mem[wr_ptr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      res_count <= '0;
      s_tready  <= 1'b0;
    end else begin
      if (s1_valid) begin
        wr_ptr <= wr_ptr + RES_PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + RES_PW'(1);
      end
      res_count <= res_count_next;
      // hold off input unless queue plus stage leave a free slot
      s_tready  <= ((res_count_next + RES_CW'(accept)) < RES_CW'(RES_DEPTH));
    end
  end

  assign res_head = res_mem[rd_ptr];
  assign m_tvalid = (res_count != '0);
  assign m_tdata  = {3'b000, res_head.sample_valid, res_head.sample_value,
                     res_head.framing_error, res_head.frame_done,
                     res_head.ack_match, res_head.ack_complete};

  // Queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ((res_count < RES_CW'(RES_DEPTH)) || pop))
    else $error("result queue overflow");

  // Accepting an item leaves room for it in the queue
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> ((res_count + RES_CW'(s1_valid)) < RES_CW'(RES_DEPTH)))
    else $error("ready raised without queue room");

  // A good terminator makes the committed bank available and flips it
  a_commit: assert property (@(posedge clk) disable iff (rst)
    (accept && flags_next.frame_done) |=>
      (frame_available && (committed_bank != $past(committed_bank))))
    else $error("commit did not swap banks");

  // A read answered valid only comes from a committed frame
  a_read_committed: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_flags.rd_valid) |-> frame_available)
    else $error("read answered before any commit");

  // Acknowledge, commit and error reports never share a result
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ($countones({s1_flags.ack_complete, s1_flags.frame_done,
                              s1_flags.framing_error, s1_flags.rd_valid}) <= 1))
    else $error("conflicting result flags");

endmodule
